/* rtl/assert_macros.svh */
// Shared assertion macros. Clock and reset are taken from the module scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NTS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define NTS_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("assertion failed");
`else
`define NTS_ASSERT(lbl, prop)
`define NTS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* rtl/nts_pkg.sv */
`default_nettype none
package nts_pkg;

   localparam int ALPHABET_SIZE_DEF = 26;
   localparam int ENTRY_BITS_DEF    = 16;
   localparam int MAX_TEXT_LEN_DEF  = 1024;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   localparam int IDX_W   = 15;
   localparam int VALUE_W = 16;
   localparam int COUNT_W = 11;
   localparam int SCORE_W = 32;

   localparam logic [1:0] ORDER_TRIGRAM = 2'd3;
   localparam logic [1:0] ORDER_RESET   = 2'd3;

   typedef enum logic [1:0] {
      REQ_LETTER = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CMD_SCORE = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_op_type;

   typedef struct packed {
      logic [1:0]                req_type;
      logic [4:0]                letter;
      logic                      last_letter;
      logic [IDX_W-1:0]          entry_index;
      logic signed [VALUE_W-1:0] entry_value;
   } req_word_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] text_score;
      logic [COUNT_W-1:0]        letters_seen;
   } rsp_word_type;

   typedef struct packed {
      cmd_op_type                op;
      logic [IDX_W-1:0]          addr;
      logic signed [VALUE_W-1:0] value;
      logic                      add_en;
      logic                      last;
      logic [COUNT_W-1:0]        count;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage
`default_nettype wire

/* rtl/nts_fifo.sv */
`default_nettype none
`include "assert_macros.svh"
module nts_fifo #(
   parameter type ITEM_type = logic,
   parameter int  DEPTH     = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire ITEM_type                     wr_data,
   output logic                              full,
   input  wire logic                         rd_en,
   output ITEM_type                          rd_data,
   output logic                              empty,
   output logic [$clog2(DEPTH+1)-1:0]        count
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   ITEM_type           store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               wr_ok, rd_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = store_ff[rd_ptr_ff];
   assign wr_ok   = wr_en && !full;
   assign rd_ok   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_ok && !rd_ok) begin
         count_in = count_ff + 1'b1;
      end else if (rd_ok && !wr_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `NTS_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

/* rtl/nts_front.sv */
`default_nettype none
module nts_front #(
   parameter int ALPHABET_SIZE = nts_pkg::ALPHABET_SIZE_DEF,
   parameter int MAX_TEXT_LEN  = nts_pkg::MAX_TEXT_LEN_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire nts_pkg::req_word_type req,
   input  wire logic                 csr_write,
   input  wire logic [1:0]           csr_wdata,
   output logic                      cmd_push,
   output nts_pkg::cmd_type          cmd
);
   localparam int SYM_W       = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int PAIR_W      = $clog2(ALPHABET_SIZE * ALPHABET_SIZE);
   localparam int STORE_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int FILL_W      = $clog2(MAX_TEXT_LEN + 1);

   logic [1:0]        order_ff, order_in;
   logic [SYM_W-1:0]  newer_ff, newer_in;
   logic [PAIR_W-1:0] hist_ff, hist_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic [SYM_W-1:0]  cur;
   logic [PAIR_W-1:0] pair_idx;
   logic [ADDR_W-1:0] tri_idx;
   logic [FILL_W-1:0] fill_sat;
   logic              trigram;
   logic              add_en;

   always_comb begin
      if ({1'b0, req.letter} >= 6'(ALPHABET_SIZE)) begin
         cur = SYM_W'(ALPHABET_SIZE - 1);
      end else begin
         cur = req.letter[SYM_W-1:0];
      end
      pair_idx = PAIR_W'(newer_ff) * PAIR_W'(ALPHABET_SIZE) + PAIR_W'(cur);
      tri_idx  = ADDR_W'(hist_ff) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(cur);
      trigram  = (order_ff == nts_pkg::ORDER_TRIGRAM);
      add_en   = trigram ? (fill_ff >= FILL_W'(2)) : (fill_ff != '0);
      fill_sat = (fill_ff < FILL_W'(MAX_TEXT_LEN)) ? fill_ff + 1'b1 : fill_ff;
   end

   always_comb begin
      order_in = csr_write ? csr_wdata : order_ff;
      newer_in = newer_ff;
      hist_in  = hist_ff;
      fill_in  = fill_ff;
      cmd_push = 1'b0;
      cmd      = '0;
      cmd.op   = nts_pkg::CMD_SCORE;
      if (accept) begin
         unique case (nts_pkg::req_kind_type'(req.req_type))
            nts_pkg::REQ_LETTER: begin
               cmd_push   = 1'b1;
               cmd.op     = nts_pkg::CMD_SCORE;
               cmd.addr   = trigram ? nts_pkg::IDX_W'(tri_idx)
                                    : nts_pkg::IDX_W'(pair_idx);
               cmd.add_en = add_en;
               cmd.last   = req.last_letter;
               cmd.count  = nts_pkg::COUNT_W'(fill_sat);
               if (req.last_letter) begin
                  newer_in = '0;
                  hist_in  = '0;
                  fill_in  = '0;
               end else begin
                  newer_in = cur;
                  hist_in  = pair_idx;
                  fill_in  = fill_sat;
               end
            end
            nts_pkg::REQ_WRITE: begin
               cmd_push  = ({1'b0, req.entry_index} < 16'(STORE_DEPTH));
               cmd.op    = nts_pkg::CMD_WRITE;
               cmd.addr  = req.entry_index;
               cmd.value = req.entry_value;
            end
            nts_pkg::REQ_CLEAR: begin
               cmd_push = 1'b1;
               cmd.op   = nts_pkg::CMD_CLEAR;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= nts_pkg::ORDER_RESET;
         newer_ff <= '0;
         hist_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         order_ff <= order_in;
         newer_ff <= newer_in;
         hist_ff  <= hist_in;
         fill_ff  <= fill_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/nts_back.sv */
`default_nettype none
`include "assert_macros.svh"
module nts_back #(
   parameter int ALPHABET_SIZE = nts_pkg::ALPHABET_SIZE_DEF,
   parameter int ENTRY_BITS    = nts_pkg::ENTRY_BITS_DEF,
   parameter int RSP_DEPTH     = nts_pkg::RSP_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           cmd_valid,
   input  wire nts_pkg::cmd_type               cmd,
   output logic                                cmd_pop,
   input  wire logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count,
   output logic                                res_push,
   output nts_pkg::rsp_word_type               res,
   output nts_pkg::back_status_type            status
);
   localparam int STORE_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int RCNT_W      = $clog2(RSP_DEPTH + 1);
   localparam int SW          = nts_pkg::SCORE_W;

   logic signed [ENTRY_BITS-1:0] score_mem_ff [STORE_DEPTH];

   logic                         sweep_ff, sweep_in;
   logic                         init_ff, init_in;
   logic [ADDR_W-1:0]            sweep_addr_ff, sweep_addr_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_add_ff, s1_last_ff;
   logic [nts_pkg::COUNT_W-1:0]  s1_count_ff;
   logic signed [ENTRY_BITS-1:0] rdata_ff;
   logic signed [SW-1:0]         sum_ff, sum_in;

   logic                         mem_we, mem_re;
   logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
   logic signed [ENTRY_BITS-1:0] mem_wdata;
   logic                         room;
   logic [SW:0]                  wide;
   logic signed [SW-1:0]         sum_add;

   assign room = ({1'b0, rsp_count} + (RCNT_W+1)'(s1_valid_ff)) < (RCNT_W+1)'(RSP_DEPTH);
   assign cmd_pop = cmd_valid && !sweep_ff && room;
   assign status.init_busy = init_ff;

   always_comb begin
      sweep_in      = sweep_ff;
      init_in       = init_ff;
      sweep_addr_in = sweep_addr_ff;
      s1_valid_in   = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = sweep_addr_ff;
      mem_raddr     = cmd.addr[ADDR_W-1:0];
      mem_wdata     = '0;
      if (sweep_ff) begin
         mem_we = 1'b1;
         if (sweep_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            sweep_in = 1'b0;
            init_in  = 1'b0;
         end else begin
            sweep_addr_in = sweep_addr_ff + 1'b1;
         end
      end else if (cmd_pop) begin
         unique case (cmd.op)
            nts_pkg::CMD_SCORE: begin
               mem_re      = 1'b1;
               s1_valid_in = 1'b1;
            end
            nts_pkg::CMD_WRITE: begin
               mem_we    = 1'b1;
               mem_waddr = cmd.addr[ADDR_W-1:0];
               mem_wdata = ENTRY_BITS'(cmd.value);
            end
            nts_pkg::CMD_CLEAR: begin
               sweep_in      = 1'b1;
               sweep_addr_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // accumulate with saturation
   always_comb begin
      wide = {sum_ff[SW-1], sum_ff} + (SW+1)'(rdata_ff);
      if (wide[SW] != wide[SW-1]) begin
         sum_add = wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         sum_add = wide[SW-1:0];
      end
      if (!s1_add_ff) begin
         sum_add = sum_ff;
      end
      res_push         = s1_valid_ff && s1_last_ff;
      res.text_score   = sum_add;
      res.letters_seen = s1_count_ff;
      if (!s1_valid_ff) begin
         sum_in = sum_ff;
      end else if (s1_last_ff) begin
         sum_in = '0;
      end else begin
         sum_in = sum_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         init_ff       <= 1'b1;
         sweep_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         sum_ff        <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         init_ff       <= init_in;
         sweep_addr_ff <= sweep_addr_in;
         s1_valid_ff   <= s1_valid_in;
         sum_ff        <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_add_ff   <= cmd.add_en;
         s1_last_ff  <= cmd.last;
         s1_count_ff <= cmd.count;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         score_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= score_mem_ff[mem_raddr];
      end
   end

   `NTS_ASSERT(a_res_room, res_push |-> rsp_count < RCNT_W'(RSP_DEPTH))
   `NTS_ASSERT(a_sum_cleared, s1_valid_ff && s1_last_ff |=> sum_ff == '0)
   `NTS_ASSERT(a_sweep_ends, sweep_ff && sweep_addr_ff == ADDR_W'(STORE_DEPTH - 1) |=> !sweep_ff)

endmodule
`default_nettype wire

/* rtl/ngram_text_scorer.sv */
// N-gram text scorer.
// Input queue: drive req_word and push; a word is taken on an edge with push high
// and full low. Letters (kind 0) slide a two- or three-letter window; each full
// window adds its table score to a saturating 32-bit sum. The letter marked last
// yields one result word (score, letter count) and clears the window and sum.
// Kind 1 writes one table entry, kind 2 zeroes the table.
// Result queue: a word waits on rsp_word while empty is low; pop takes it.
// Config: csr_wdata with valid/ready sets the order (3 trigram, else bigram);
// ready is always high. Write only while no work is outstanding.
// Throughput: one word per cycle while full is low. A result passes the command queue,
// read register and result queue. A table clear stalls the back end while it zeroes all
// table entries; the front keeps taking words until the 4-deep command queue fills.
// Reset: the table is zeroed by the same pass, full stays high meanwhile.
// A stalled result queue (4 deep) holds back the command queue and then full.
`default_nettype none
module ngram_text_scorer #(
   parameter int ALPHABET_SIZE = nts_pkg::ALPHABET_SIZE_DEF,
   parameter int ENTRY_BITS    = nts_pkg::ENTRY_BITS_DEF,
   parameter int MAX_TEXT_LEN  = nts_pkg::MAX_TEXT_LEN_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire nts_pkg::req_word_type req_word,
   output logic                       empty,
   input  wire logic                  pop,
   output nts_pkg::rsp_word_type      rsp_word,
   input  wire logic                  valid,
   output logic                       ready,
   input  wire logic [1:0]            csr_wdata
);
   localparam int RCNT_W = $clog2(nts_pkg::RSP_DEPTH + 1);

   logic                      accept;
   logic                      cmd_push, cmd_full, cmd_empty, cmd_pop;
   nts_pkg::cmd_type          cmd_wr, cmd_rd;
   logic                      res_push;
   nts_pkg::rsp_word_type     res;
   logic [RCNT_W-1:0]         rsp_count;
   nts_pkg::back_status_type  back_status;

   assign full   = cmd_full || back_status.init_busy;
   assign accept = push && !full;
   assign ready  = 1'b1;

   nts_front #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .MAX_TEXT_LEN  (MAX_TEXT_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_word),
      .csr_write (valid && ready),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd       (cmd_wr)
   );

   nts_fifo #(
      .ITEM_type (nts_pkg::cmd_type),
      .DEPTH     (nts_pkg::CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty),
      .count   ()
   );

   nts_back #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .ENTRY_BITS    (ENTRY_BITS),
      .RSP_DEPTH     (nts_pkg::RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .res_push  (res_push),
      .res       (res),
      .status    (back_status)
   );

   nts_fifo #(
      .ITEM_type (nts_pkg::rsp_word_type),
      .DEPTH     (nts_pkg::RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res),
      .full    (),
      .rd_en   (pop),
      .rd_data (rsp_word),
      .empty   (empty),
      .count   (rsp_count)
   );

endmodule
`default_nettype wire

/* tb/ngram_text_scorer_checker.sv */
module ngram_text_scorer_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  nts_pkg::req_word_type req_word,
   input  logic                  empty,
   input  logic                  pop,
   input  nts_pkg::rsp_word_type rsp_word,
   input  logic                  valid,
   input  logic                  ready,
   input  logic [1:0]            csr_wdata,
   output int                    fail_count,
   output int                    scores_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ALPHA       = nts_pkg::ALPHABET_SIZE_DEF;
   localparam int     TABLE_DEPTH = ALPHA * ALPHA * ALPHA;
   localparam int     MAX_LEN     = nts_pkg::MAX_TEXT_LEN_DEF;
   localparam longint SUM_MAX     = 64'sd2147483647;
   localparam longint SUM_MIN     = -64'sd2147483648;

   logic signed [nts_pkg::VALUE_W-1:0] entry_table [TABLE_DEPTH];
   logic [4:0]                         lag2_code;
   logic [4:0]                         lag1_code;
   int unsigned                        run_len;
   logic signed [nts_pkg::SCORE_W-1:0] run_total;
   logic [1:0]                         order_sel;
   nts_pkg::rsp_word_type              expected_scores [$];
   int                                 mismatches;

   function automatic void wipe_table();
      for (int i = 0; i < TABLE_DEPTH; i++)
         entry_table[i] = '0;
   endfunction

   function automatic void clear_text_state();
      lag2_code = '0;
      lag1_code = '0;
      run_len   = 0;
      run_total = '0;
   endfunction

   function automatic void score_letter(logic [4:0] code, logic last);
      logic [4:0]            cur;
      bit                    trigram_mode;
      int unsigned           need;
      int unsigned           idx;
      longint                acc;
      nts_pkg::rsp_word_type r;
      cur = (code >= ALPHA) ? 5'(ALPHA - 1) : code;
      trigram_mode = (order_sel == nts_pkg::ORDER_TRIGRAM);
      need = trigram_mode ? 2 : 1;
      if (run_len >= need) begin
         if (trigram_mode)
            idx = (lag2_code * ALPHA + lag1_code) * ALPHA + cur;
         else
            idx = lag1_code * ALPHA + cur;
         acc = longint'(run_total) + longint'(entry_table[idx]);
         if (acc > SUM_MAX)
            acc = SUM_MAX;
         if (acc < SUM_MIN)
            acc = SUM_MIN;
         run_total = acc[31:0];
      end
      lag2_code = lag1_code;
      lag1_code = cur;
      if (run_len < MAX_LEN)
         run_len++;
      if (last) begin
         r.text_score   = run_total;
         r.letters_seen = run_len[nts_pkg::COUNT_W-1:0];
         expected_scores.push_back(r);
         clear_text_state();
      end
   endfunction

   always @(posedge clock) begin : observe
      nts_pkg::rsp_word_type want;
      if (reset) begin
         wipe_table();
         clear_text_state();
         order_sel = nts_pkg::ORDER_RESET;
         expected_scores.delete();
      end else begin
         if (pop && !empty) begin
            if (expected_scores.size() == 0) begin
               mismatches++;
               $display("%0t: result word with none expected: score %0d, count %0d",
                        $time, $signed(rsp_word.text_score), rsp_word.letters_seen);
            end else begin
               want = expected_scores.pop_front();
               if (rsp_word.text_score !== want.text_score) begin
                  mismatches++;
                  $display("%0t: text_score expected %0d, actual %0d", $time,
                           $signed(want.text_score), $signed(rsp_word.text_score));
               end
               if (rsp_word.letters_seen !== want.letters_seen) begin
                  mismatches++;
                  $display("%0t: letters_seen expected %0d, actual %0d", $time,
                           want.letters_seen, rsp_word.letters_seen);
               end
            end
         end
         if (push && !full) begin
            case (req_word.req_type)
               nts_pkg::REQ_LETTER: score_letter(req_word.letter, req_word.last_letter);
               nts_pkg::REQ_WRITE: begin
                  if (req_word.entry_index < TABLE_DEPTH)
                     entry_table[req_word.entry_index] = req_word.entry_value;
               end
               nts_pkg::REQ_CLEAR: wipe_table();
               default: ;
            endcase
         end
         // the new order applies from the next word on
         if (valid && ready)
            order_sel = csr_wdata;
      end
      fail_count <= mismatches;
      scores_due <= expected_scores.size();
   end

endmodule

/* tb/ngram_text_scorer_tb.sv */
module ngram_text_scorer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         TABLE_DEPTH   = nts_pkg::ALPHABET_SIZE_DEF ** 3;
   localparam int         SETTLE_CYCLES = TABLE_DEPTH + 64;
   localparam int         IDLE_LIMIT    = 4 * TABLE_DEPTH;
   localparam int         LONG_HOLD     = 400;
   localparam int         RUN_TEXT      = 12;
   localparam logic [1:0] REQ_SPARE     = 2'd3;

   typedef enum {DRAIN_FAST, DRAIN_RANDOM, DRAIN_SLOW} drain_mode_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  push      = 1'b0;
   logic                  pop       = 1'b0;
   logic                  valid     = 1'b0;
   logic [1:0]            csr_wdata = nts_pkg::ORDER_RESET;
   nts_pkg::req_word_type req_word  = '0;
   logic                  full;
   logic                  empty;
   logic                  ready;
   nts_pkg::rsp_word_type rsp_word;
   int                    fail_count;
   int                    scores_due;
   int                    hold_requests = 0;
   int                    holds_served  = 0;
   int                    burst_left    = 0;
   int                    idle_cycles   = 0;

   ngram_text_scorer DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word),
      .valid     (valid),
      .ready     (ready),
      .csr_wdata (csr_wdata)
   );

   ngram_text_scorer_checker score_check (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_word   (req_word),
      .empty      (empty),
      .pop        (pop),
      .rsp_word   (rsp_word),
      .valid      (valid),
      .ready      (ready),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .scores_due (scores_due)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (valid && ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("ngram_text_scorer_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random pop pattern, with one long hold-off on request
   initial begin : drain_side
      drain_mode_type mode;
      int             seg_left;
      mode = DRAIN_FAST;
      seg_left = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_served++;
         end else begin
            if (seg_left == 0) begin
               mode = drain_mode_type'($urandom_range(0, 2));
               seg_left = $urandom_range(1, 60);
            end
            seg_left--;
            case (mode)
               DRAIN_FAST:   pop <= 1'b1;
               DRAIN_RANDOM: pop <= 1'($urandom_range(0, 1));
               default:      pop <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   task automatic offer_word(nts_pkg::req_word_type w, bit steady);
      int gap;
      if (!steady && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_word <= w;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      if (burst_left > 0)
         burst_left--;
   endtask

   task automatic send_letter(logic [4:0] code, bit last, bit steady);
      nts_pkg::req_word_type w;
      w.req_type    = nts_pkg::REQ_LETTER;
      w.letter      = code;
      w.last_letter = last;
      w.entry_index = 15'($urandom);
      w.entry_value = 16'($urandom);
      offer_word(w, steady);
   endtask

   task automatic send_other(logic [1:0] kind, logic [14:0] idx, logic [15:0] val, bit last);
      nts_pkg::req_word_type w;
      w.req_type    = kind;
      w.letter      = 5'($urandom);
      w.last_letter = last;
      w.entry_index = idx;
      w.entry_value = val;
      offer_word(w, 1'b0);
   endtask

   function automatic logic [4:0] pick_letter();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 5'($urandom_range(0, 3));
      else if (r < 95)
         return 5'($urandom_range(0, 25));
      return 5'($urandom_range(26, 31));
   endfunction

   // mostly indexes that texts over a small alphabet actually reach
   function automatic logic [14:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 15'($urandom_range(0, 3) * 676 + $urandom_range(0, 3) * 26
                    + $urandom_range(0, 3));
      else if (r < 85)
         return 15'($urandom_range(0, 3) * 26 + $urandom_range(0, 3));
      else if (r < 95)
         return 15'($urandom_range(0, TABLE_DEPTH - 1));
      return 15'($urandom_range(TABLE_DEPTH, 32767));
   endfunction

   function automatic logic [15:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 16'h7FFF;
      else if (r < 20)
         return 16'h8000;
      return 16'($urandom);
   endfunction

   task automatic send_text(int len, bit finish);
      for (int i = 0; i < len; i++)
         send_letter(pick_letter(), finish && (i == len - 1), 1'b0);
   endtask

   // no result marks the end of a table clear, so wait out a full pass
   task automatic write_order(logic [1:0] order);
      push <= 1'b0;
      do @(posedge clock); while (scores_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      valid <= 1'b1;
      csr_wdata <= order;
      do @(posedge clock); while (!ready);
      valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [1:0] order_plan [6];
      int         sent;
      int         n;
      int         r;
      int         wipes_left;
      order_plan = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
      wipes_left = 3;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_other(nts_pkg::REQ_WRITE, 15'd0, 16'h7FFF, 1'b1);
      send_other(nts_pkg::REQ_WRITE, 15'(TABLE_DEPTH - 1), 16'h8000, 1'b0);
      send_other(nts_pkg::REQ_WRITE, 15'h7FFF, 16'h1234, 1'b0);
      send_other(nts_pkg::REQ_WRITE, 15'(TABLE_DEPTH), 16'h0055, 1'b1);
      send_other(REQ_SPARE, 15'd0, 16'h0001, 1'b1);
      send_letter(5'd0, 1'b0, 1'b0);
      send_letter(5'd0, 1'b0, 1'b0);
      send_letter(5'd0, 1'b1, 1'b0);
      // codes past Z clamp to Z
      send_letter(5'd31, 1'b0, 1'b0);
      send_letter(5'd30, 1'b0, 1'b0);
      send_letter(5'd25, 1'b1, 1'b0);
      send_letter(5'd7, 1'b1, 1'b0);
      // runs of one letter on the extreme entries, back to back
      for (int i = 0; i < RUN_TEXT; i++)
         send_letter(5'd0, i == RUN_TEXT - 1, 1'b1);
      for (int i = 0; i < RUN_TEXT; i++)
         send_letter(5'd25, i == RUN_TEXT - 1, 1'b1);
      send_other(nts_pkg::REQ_CLEAR, 15'($urandom), 16'($urandom), 1'b1);
      send_letter(5'd0, 1'b0, 1'b0);
      send_letter(5'd0, 1'b0, 1'b0);
      send_letter(5'd0, 1'b1, 1'b0);

      foreach (order_plan[p]) begin
         write_order(order_plan[p]);
         if (p == 3) begin
            hold_requests <= hold_requests + 1;
            repeat (40) send_letter(pick_letter(), 1'b1, 1'b1);
         end
         sent = 0;
         while (sent < 50) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
               send_text(n, 1'b1);
               sent += n;
            end else if (r < 85) begin
               n = $urandom_range(1, 4);
               repeat (n) send_other(nts_pkg::REQ_WRITE, pick_index(), pick_value(),
                                     1'($urandom_range(0, 1)));
               sent += n;
            end else if (r < 93) begin
               send_other(REQ_SPARE, 15'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
            end else if (r < 95 && wipes_left > 0) begin
               send_other(nts_pkg::REQ_CLEAR, 15'($urandom), 16'($urandom),
                          1'($urandom_range(0, 1)));
               wipes_left--;
               sent++;
            end else begin
               send_letter(pick_letter(), 1'b0, 1'b0);
               sent++;
            end
         end
         // leave a text open across the next order change
         if ($urandom_range(0, 1))
            send_text($urandom_range(1, 2), 1'b0);
      end
      send_text($urandom_range(1, 4), 1'b1);

      push <= 1'b0;
      do @(posedge clock); while (scores_due != 0);
      repeat (64) @(posedge clock);
      if (fail_count == 0)
         $display("ngram_text_scorer_tb: PASS");
      else
         $display("ngram_text_scorer_tb: FAIL");
      $finish;
   end

endmodule
